// ===== src/rau_pkg.sv =====
// shared types and constants of the rational arithmetic unit
`default_nettype none
package rau_pkg;

   // operation codes
   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_NEG = 4'd4,
      OP_EQ  = 4'd5,
      OP_NE  = 4'd6,
      OP_LT  = 4'd7,
      OP_GT  = 4'd8,
      OP_LE  = 4'd9,
      OP_GE  = 4'd10
   } op_type;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // request transaction
   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   // response transaction
   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               compare_true;
      logic [1:0]         status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic   load;
      logic   mul0;
      logic   mul1;
      logic   mul2;
      logic   comb;
      logic   gcd_init;
      logic   gcd_step;
      logic   gcd_take;
      logic   div_start;
      logic   div_den;
      logic   div_take;
      logic   finish;
      op_type op;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic gcd_done;
      logic g_one;
      logic b_zero;
      logic div_done;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit
//
// A transaction is taken when start is high and busy is low; its result
// appears on rsp_item for exactly one cycle with rsp_valid high, and the
// receiver cannot stall it. One transaction is worked on at a time. The
// three cross products go through one shared multiplier, one per cycle.
// Negate, comparisons, unused codes and divide by zero skip the reduction
// and go from the combine state straight to the final state. Add, sub,
// mul and div reduce the result with a binary gcd over 2*VALUE_BITS bit
// magnitudes, one step a cycle, and then, unless the gcd is one, divide
// numerator and denominator in a shared restoring divider at one bit a
// cycle. busy falls in the cycle the response is shown, so the next
// transaction may be taken there.
`default_nettype none
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_item.opcode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath
   rau_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_item),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_item)
   );

endmodule
`default_nettype wire

// ===== src/rau_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module rau_div #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // one shift and trial subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CW'(WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/rau_datapath.sv =====
// operand registers, multiplier, binary gcd, divider and result register
`default_nettype none
module rau_datapath
   import rau_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   output rsp_type          rsp
);
   localparam int MW = VALUE_BITS;
   localparam int PW = 2 * VALUE_BITS;
   localparam int KW = $clog2(PW + 1);

   // sign and magnitude of the low bits of a field
   function automatic logic [MW:0] to_sm(input logic [31:0] raw);
      logic [MW-1:0] v;
      logic          n;
      v = raw[MW-1:0];
      n = v[MW-1];
      return {n, (n ? (~v + MW'(1)) : v)};
   endfunction

   logic          an_ff, an_in, bn_ff, bn_in;
   logic [MW-1:0] am_ff, am_in, ad_ff, ad_in, bm_ff, bm_in, bd_ff, bd_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in, t_ff, t_in;
   logic          xn_ff, xn_in;
   logic          cmp_ff, cmp_in;
   logic [PW-1:0] gu_ff, gu_in, gv_ff, gv_in, g_ff, g_in;
   logic [KW-1:0] gk_ff, gk_in;
   rsp_type       rsp_ff, rsp_in;

   logic [MW:0]   sa_n, sa_d, sb_n, sb_d;
   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod;
   logic          bneg;
   logic          l_neg, r_neg, c_lt, c_eq, c_gt;
   logic [PW-1:0] lim;
   logic          r_neg_res, bad;
   logic          div_done;
   logic [PW-1:0] quotient;

   assign sa_n = to_sm(req.a_num);
   assign sa_d = to_sm(req.a_den);
   assign sb_n = to_sm(req.b_num);
   assign sb_d = to_sm(req.b_den);

   // shared multiplier operand selection
   always_comb begin
      mul_a = ad_ff;
      mul_b = bd_ff;
      if (cmd.mul0) begin
         mul_a = am_ff;
         mul_b = (cmd.op == OP_MUL) ? bm_ff : bd_ff;
      end else if (cmd.mul1) begin
         mul_b = (cmd.op == OP_DIV) ? bm_ff : bd_ff;
      end else if (cmd.mul2) begin
         mul_b = bm_ff;
      end
   end
   assign prod = PW'(mul_a) * PW'(mul_b);

   // exact comparison of cross products
   always_comb begin
      l_neg = an_ff && (x_ff != '0);
      r_neg = bn_ff && (t_ff != '0);
      c_eq  = (l_neg == r_neg) && (x_ff == t_ff);
      if (l_neg != r_neg) c_lt = l_neg;
      else if (x_ff == t_ff) c_lt = 1'b0;
      else if (!l_neg) c_lt = x_ff < t_ff;
      else c_lt = x_ff > t_ff;
      c_gt = !c_lt && !c_eq;
   end

   assign bneg = (cmd.op == OP_SUB) ? (!bn_ff && (bm_ff != '0)) : bn_ff;
   assign lim  = PW'(1) << (MW - 1);
   assign r_neg_res = xn_ff && (x_ff != '0);
   assign bad  = (y_ff >= lim) || (r_neg_res ? (x_ff > lim) : (x_ff >= lim));

   // main register update
   always_comb begin
      an_in = an_ff; am_in = am_ff; ad_in = ad_ff;
      bn_in = bn_ff; bm_in = bm_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; t_in = t_ff; xn_in = xn_ff;
      cmp_in = cmp_ff;
      gu_in = gu_ff; gv_in = gv_ff; gk_in = gk_ff; g_in = g_ff;
      rsp_in = rsp_ff;

      // operand load, zero denominator gives 0/1
      if (cmd.load) begin
         if (sa_d[MW-1:0] == '0) begin
            an_in = 1'b0; am_in = '0; ad_in = MW'(1);
         end else begin
            am_in = sa_n[MW-1:0];
            ad_in = sa_d[MW-1:0];
            an_in = (sa_n[MW-1:0] != '0) && (sa_n[MW] != sa_d[MW]);
         end
         if (sb_d[MW-1:0] == '0) begin
            bn_in = 1'b0; bm_in = '0; bd_in = MW'(1);
         end else begin
            bm_in = sb_n[MW-1:0];
            bd_in = sb_d[MW-1:0];
            bn_in = (sb_n[MW-1:0] != '0) && (sb_n[MW] != sb_d[MW]);
         end
      end

      if (cmd.mul0) x_in = prod;
      if (cmd.mul1) y_in = prod;
      if (cmd.mul2) t_in = prod;

      // combine products by operation
      if (cmd.comb) begin
         case (cmd.op)
            OP_ADD, OP_SUB: begin
               if (an_ff == bneg) begin
                  x_in  = x_ff + t_ff;
                  xn_in = an_ff;
               end else if (x_ff >= t_ff) begin
                  x_in  = x_ff - t_ff;
                  xn_in = an_ff;
               end else begin
                  x_in  = t_ff - x_ff;
                  xn_in = bneg;
               end
            end
            OP_MUL, OP_DIV: xn_in = (an_ff != bn_ff);
            OP_NEG: begin
               x_in  = PW'(am_ff);
               y_in  = PW'(ad_ff);
               xn_in = !an_ff && (am_ff != '0);
            end
            OP_EQ: cmp_in = c_eq;
            OP_NE: cmp_in = !c_eq;
            OP_LT: cmp_in = c_lt;
            OP_GT: cmp_in = c_gt;
            OP_LE: cmp_in = !c_gt;
            OP_GE: cmp_in = !c_lt;
            default: cmp_in = 1'b0;
         endcase
      end

      // binary gcd, one step a cycle
      if (cmd.gcd_init) begin
         gu_in = x_ff;
         gv_in = y_ff;
         gk_in = '0;
      end else if (cmd.gcd_step) begin
         if (!gu_ff[0] && !gv_ff[0]) begin
            gu_in = gu_ff >> 1;
            gv_in = gv_ff >> 1;
            gk_in = gk_ff + KW'(1);
         end else if (!gu_ff[0]) begin
            gu_in = gu_ff >> 1;
         end else if (!gv_ff[0]) begin
            gv_in = gv_ff >> 1;
         end else if (gu_ff >= gv_ff) begin
            gu_in = gu_ff - gv_ff;
         end else begin
            gv_in = gv_ff - gu_ff;
         end
      end
      if (cmd.gcd_take) g_in = gv_ff << gk_ff;

      if (cmd.div_take) begin
         if (cmd.div_den) y_in = quotient;
         else x_in = quotient;
      end

      // result formatting
      if (cmd.finish) begin
         rsp_in.res_num      = '0;
         rsp_in.res_den      = 31'd1;
         rsp_in.compare_true = 1'b0;
         rsp_in.status       = ST_OK;
         case (cmd.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG: begin
               if ((cmd.op == OP_DIV) && (bm_ff == '0)) begin
                  rsp_in.status = ST_ZERO_DEN;
               end else if (bad) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  rsp_in.res_num = r_neg_res ? (32'd0 - 32'(x_ff)) : 32'(x_ff);
                  rsp_in.res_den = 31'(y_ff);
               end
            end
            OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: rsp_in.compare_true = cmp_ff;
            default: rsp_in.status = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      an_ff <= an_in; am_ff <= am_in; ad_ff <= ad_in;
      bn_ff <= bn_in; bm_ff <= bm_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; t_ff <= t_in; xn_ff <= xn_in;
      cmp_ff <= cmp_in;
      gu_ff <= gu_in; gv_ff <= gv_in; gk_ff <= gk_in; g_ff <= g_in;
      rsp_ff <= rsp_in;
   end

   // shared divider for the reduction quotients
   rau_div #(
      .WIDTH (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_den ? y_ff : x_ff),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign stat.gcd_done = (gu_ff == '0);
   assign stat.g_one    = (g_ff == PW'(1));
   assign stat.b_zero   = (bm_ff == '0);
   assign stat.div_done = div_done;
   assign rsp           = rsp_ff;

endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
// sequencing state machine of the rational arithmetic unit
`default_nettype none
module rau_ctrl
   import rau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [3:0]  req_op,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd,
   output logic             busy,
   output logic             rsp_valid
);
   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_MUL0  = 13'b0000000000010,
      S_MUL1  = 13'b0000000000100,
      S_MUL2  = 13'b0000000001000,
      S_COMB  = 13'b0000000010000,
      S_GINIT = 13'b0000000100000,
      S_GSTEP = 13'b0000001000000,
      S_GTAKE = 13'b0000010000000,
      S_DIVN  = 13'b0000100000000,
      S_WAITN = 13'b0001000000000,
      S_DIVD  = 13'b0010000000000,
      S_WAITD = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      reduce;

   assign accept = start && (state_ff == S_IDLE);
   assign reduce = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_MUL) ||
                   ((op_ff == OP_DIV) && !stat.b_zero);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.load     = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul0 = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = reduce ? S_GINIT : S_FIN;
         end
         S_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = S_GSTEP;
         end
         S_GSTEP: begin
            cmd.gcd_step = !stat.gcd_done;
            if (stat.gcd_done) state_in = S_GTAKE;
         end
         S_GTAKE: begin
            cmd.gcd_take = 1'b1;
            state_in     = S_DIVN;
         end
         S_DIVN: begin
            if (stat.g_one) begin
               state_in = S_FIN;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_WAITN;
            end
         end
         S_WAITN: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_DIVD;
            end
         end
         S_DIVD: begin
            cmd.div_den   = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_WAITD;
         end
         S_WAITD: begin
            cmd.div_den = 1'b1;
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a response strobe only follows the final state
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_FIN))
      else $error("response strobe without final state");

   // an accepted transaction starts the multiply sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> (state_ff == S_MUL0))
      else $error("accepted transaction did not start");

   // one response per transaction, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

endmodule
`default_nettype wire
